>>> rtl/dvrt_pkg.sv
// dvrt_pkg: shared types and constants of the distance-vector route table
// holds item codes, status codes, register indexes and the word structs
// no dependencies
`default_nettype none

package dvrt_pkg;

   // item kinds
   localparam logic [1:0] KIND_CONNECT = 2'd0;
   localparam logic [1:0] KIND_ADVERT  = 2'd1;
   localparam logic [1:0] KIND_LOOKUP  = 2'd2;
   localparam logic [1:0] KIND_DUMP    = 2'd3;

   // result status codes
   localparam logic [2:0] STATUS_INSTALLED = 3'd0;
   localparam logic [2:0] STATUS_IGNORED   = 3'd1;
   localparam logic [2:0] STATUS_FOUND     = 3'd2;
   localparam logic [2:0] STATUS_UNREACH   = 3'd3;
   localparam logic [2:0] STATUS_FULL      = 3'd4;
   localparam logic [2:0] STATUS_DUMP      = 3'd5;

   // register indexes
   localparam logic [7:0] CSR_OWN_ADDRESS = 8'd0;
   localparam logic [7:0] CSR_HOP_LIMIT   = 8'd1;

   localparam logic [3:0] HOP_LOCAL       = 4'd1;
   localparam logic [3:0] HOP_LIMIT_RESET = 4'd15;

   // classified item as held in the queue
   typedef struct packed {
      logic [1:0]  kind;
      logic [23:0] network;
      logic [31:0] gateway;
      logic [3:0]  item_hops;
      logic        over_limit;
   } item_type;

   // one result word
   typedef struct packed {
      logic [2:0]  status;
      logic [23:0] network;
      logic [31:0] gateway;
      logic [3:0]  metric;
      logic        entry_valid;
      logic        last;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/dvrt_front.sv
// dvrt_front: input side, takes request words and classifies them
// depends on dvrt_pkg
`default_nettype none

module dvrt_front (
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [71:0]       req_tdata,   // address, via_address, hops, zero pad
   input  wire logic [1:0]        req_tuser,   // kind
   input  wire logic [3:0]        hop_limit,
   input  wire logic              q_full,
   output logic                   push,
   output dvrt_pkg::item_type     push_item
);

   logic [31:0] address;
   logic [31:0] via_address;
   logic [3:0]  hops;
   logic [4:0]  adv_hops;
   logic        is_connect;

   assign address     = req_tdata[31:0];
   assign via_address = req_tdata[63:32];
   assign hops        = req_tdata[67:64];

   assign adv_hops   = {1'b0, hops} + 5'd1;
   assign is_connect = (req_tuser == dvrt_pkg::KIND_CONNECT);

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   always_comb begin
      push_item.kind       = req_tuser;
      push_item.network    = address[31:8];
      push_item.gateway    = is_connect ? address : via_address;
      push_item.item_hops  = is_connect ? dvrt_pkg::HOP_LOCAL : adv_hops[3:0];
      // over the limit after adding a hop
      push_item.over_limit = (adv_hops > {1'b0, hop_limit});
   end

endmodule

`default_nettype wire

>>> rtl/dvrt_queue.sv
// dvrt_queue: two-entry queue between the front and the table engine
// depends on dvrt_pkg
`default_nettype none

module dvrt_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire dvrt_pkg::item_type  push_item,
   output logic                     full,
   input  wire logic                pop,
   output dvrt_pkg::item_type       pop_item,
   output logic                     empty
);

   dvrt_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> rtl/dvrt_back.sv
// dvrt_back: table engine, match cells, slot memories and result register
// depends on dvrt_pkg
`default_nettype none

module dvrt_back #(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [31:0]         own_address,
   input  wire logic                q_empty,
   input  wire dvrt_pkg::item_type  pop_item,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output dvrt_pkg::rsp_type        rsp
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_SEARCH   = 8'b0000_0010,
      ST_SELECT   = 8'b0000_0100,
      ST_READ     = 8'b0000_1000,
      ST_EXEC     = 8'b0001_0000,
      ST_EMPTY    = 8'b0010_0000,
      ST_DUMP_RD  = 8'b0100_0000,
      ST_DUMP_OUT = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   dvrt_pkg::item_type item_ff, item_in;

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [23:0]              cell_net_ff [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] match_ff, match_in;
   logic [TABLE_ENTRIES-1:0] free_ff, free_in;
   logic                     hit_ff, hit_in;
   logic [IDX_W-1:0]         hit_idx_ff, hit_idx_in;
   logic                     free_any_ff, free_any_in;
   logic [IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]         dump_idx_ff, dump_idx_in;

   logic [23:0] mem_network  [TABLE_ENTRIES];
   logic [31:0] mem_gateway  [TABLE_ENTRIES];
   logic [3:0]  mem_hops     [TABLE_ENTRIES];
   logic [23:0] rd_net_ff;
   logic [31:0] rd_nh_ff;
   logic [3:0]  rd_hops_ff;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;

   logic             wr_want, wr_en;
   logic [IDX_W-1:0] wr_addr;

   logic                 rsp_valid_ff, rsp_valid_in;
   dvrt_pkg::rsp_type    rsp_ff, rsp_in;
   dvrt_pkg::rsp_type    exec_rsp;
   logic                 out_req, out_load;
   logic [TABLE_ENTRIES-1:0] above_mask;
   logic                 dump_last;

   // match cells, each compared in place
   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (cell_net_ff[i] == item_ff.network);
         free_in[i]  = !valid_ff[i];
      end
   end

   // lowest hit and lowest free slot
   always_comb begin
      hit_in      = 1'b0;
      hit_idx_in  = '0;
      free_any_in = 1'b0;
      free_idx_in = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_in     = 1'b1;
            hit_idx_in = IDX_W'(i);
         end
         if (free_ff[i]) begin
            free_any_in = 1'b1;
            free_idx_in = IDX_W'(i);
         end
      end
   end

   // operation decision
   always_comb begin
      exec_rsp.status      = dvrt_pkg::STATUS_IGNORED;
      exec_rsp.network     = item_ff.network;
      exec_rsp.gateway     = '0;
      exec_rsp.metric      = '0;
      exec_rsp.entry_valid = 1'b0;
      exec_rsp.last        = 1'b1;
      wr_want              = 1'b0;
      wr_addr              = hit_ff ? hit_idx_ff : free_idx_ff;
      case (item_ff.kind)
         dvrt_pkg::KIND_CONNECT: begin
            if (hit_ff || free_any_ff) begin
               wr_want = 1'b1;
            end else begin
               exec_rsp.status = dvrt_pkg::STATUS_FULL;
            end
         end
         dvrt_pkg::KIND_ADVERT: begin
            if (item_ff.over_limit) begin
               exec_rsp.status = dvrt_pkg::STATUS_IGNORED;
            end else if (hit_ff) begin
               wr_want = (item_ff.item_hops < rd_hops_ff);
            end else if (free_any_ff) begin
               wr_want = 1'b1;
            end else begin
               exec_rsp.status = dvrt_pkg::STATUS_FULL;
            end
         end
         dvrt_pkg::KIND_LOOKUP: begin
            if (hit_ff) begin
               exec_rsp.status      = dvrt_pkg::STATUS_FOUND;
               exec_rsp.gateway     = rd_nh_ff;
               exec_rsp.metric      = rd_hops_ff;
               exec_rsp.entry_valid = 1'b1;
            end else begin
               exec_rsp.status = dvrt_pkg::STATUS_UNREACH;
            end
         end
         default: begin
            exec_rsp.status = dvrt_pkg::STATUS_IGNORED;
         end
      endcase
      if (wr_want) begin
         exec_rsp.status      = dvrt_pkg::STATUS_INSTALLED;
         exec_rsp.gateway     = item_ff.gateway;
         exec_rsp.metric      = item_ff.item_hops;
         exec_rsp.entry_valid = 1'b1;
      end
   end

   // any valid slot above the dump index
   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         above_mask[i] = (i > int'(dump_idx_ff));
      end
   end
   assign dump_last = !(|(valid_ff & above_mask));

   assign out_req  = (state_ff == ST_EXEC) || (state_ff == ST_EMPTY) ||
                     (state_ff == ST_DUMP_OUT);
   assign out_load = out_req && (!rsp_valid_ff || rsp_ready);
   assign wr_en    = (state_ff == ST_EXEC) && out_load && wr_want;
   assign pop      = (state_ff == ST_IDLE) && !q_empty;

   assign rd_addr = (state_ff == ST_DUMP_RD) ? dump_idx_ff : hit_idx_ff;
   assign rd_en   = (state_ff == ST_READ) ||
                    ((state_ff == ST_DUMP_RD) && valid_ff[dump_idx_ff]);

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      dump_idx_in = dump_idx_ff;
      valid_in    = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               item_in     = pop_item;
               dump_idx_in = '0;
               if (pop_item.kind != dvrt_pkg::KIND_DUMP) begin
                  state_in = ST_SEARCH;
               end else if (|valid_ff) begin
                  state_in = ST_DUMP_RD;
               end else begin
                  state_in = ST_EMPTY;
               end
            end
         end
         ST_SEARCH: state_in = ST_SELECT;
         ST_SELECT: state_in = ST_READ;
         ST_READ:   state_in = ST_EXEC;
         ST_EXEC, ST_EMPTY: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         ST_DUMP_RD: begin
            if (valid_ff[dump_idx_ff]) begin
               state_in = ST_DUMP_OUT;
            end else begin
               dump_idx_in = dump_idx_ff + IDX_W'(1);
            end
         end
         ST_DUMP_OUT: begin
            if (out_load) begin
               if (dump_last || (dump_idx_ff == LAST_IDX)) begin
                  state_in = ST_IDLE;
               end else begin
                  dump_idx_in = dump_idx_ff + IDX_W'(1);
                  state_in    = ST_DUMP_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_in = exec_rsp;
      case (state_ff)
         ST_EMPTY: begin
            rsp_in             = '0;
            rsp_in.status      = dvrt_pkg::STATUS_DUMP;
            rsp_in.last        = 1'b1;
         end
         ST_DUMP_OUT: begin
            rsp_in.status      = dvrt_pkg::STATUS_DUMP;
            rsp_in.network     = rd_net_ff;
            rsp_in.gateway     = own_address;
            rsp_in.metric      = rd_hops_ff;
            rsp_in.entry_valid = 1'b1;
            rsp_in.last        = dump_last;
         end
         default: rsp_in = exec_rsp;
      endcase
      rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      dump_idx_ff <= dump_idx_in;
      match_ff    <= match_in;
      free_ff     <= free_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      free_any_ff <= free_any_in;
      free_idx_ff <= free_idx_in;
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
      if (wr_en) begin
         cell_net_ff[wr_addr] <= item_ff.network;
      end
   end

   // slot memories, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_network[wr_addr] <= item_ff.network;
         mem_gateway[wr_addr] <= item_ff.gateway;
         mem_hops[wr_addr]    <= item_ff.item_hops;
      end
      if (rd_en) begin
         rd_net_ff  <= mem_network[rd_addr];
         rd_nh_ff   <= mem_gateway[rd_addr];
         rd_hops_ff <= mem_hops[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // a word without an entry carries no route
   a_no_entry_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.entry_valid |-> rsp_ff.gateway == '0 && rsp_ff.metric == '0)
      else $error("word without entry carries route data");

   // a written slot becomes valid
   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(wr_addr)])
      else $error("slot write did not set valid bit");

   // only dumps give more than one word per item
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      out_load && (state_ff == ST_EXEC) |-> rsp_in.last)
      else $error("single-word item without last");

   // a dump word always comes from a valid slot
   a_dump_from_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP_OUT |-> valid_ff[dump_idx_ff])
      else $error("dump word from an empty slot");

endmodule

`default_nettype wire

>>> rtl/distance_vector_route_table_unit.sv
// distance_vector_route_table_unit: top level of the distance-vector route table
// holds the register port and joins front, queue and table engine
// depends on dvrt_pkg, dvrt_front, dvrt_queue, dvrt_back
// a connect, advertisement or lookup word is popped from the queue, then passes the search,
// select, read and update states; the next item is popped only once its result is loaded
// a dump pops, then reads slots in order and outputs each valid one, to the last valid slot
// reset clears the valid bits, the queue and the result valid flag at once, no clearing pass
// own_address resets to 0 and hop_limit to 15
`default_nettype none

module distance_vector_route_table_unit #(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request words
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // address [31:0], via_address [63:32], hops [67:64]
   input  wire logic [1:0]  req_tuser,   // kind [1:0]
   // result words
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // network [23:0], gateway [55:24], metric [59:56]
   output logic [3:0]       rsp_tuser,   // status [2:0], entry_valid [3]
   output logic             rsp_tlast,
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   logic [31:0] own_address_ff, own_address_in;
   logic [3:0]  hop_limit_ff, hop_limit_in;

   logic               q_full, q_empty, push, pop;
   dvrt_pkg::item_type push_item, pop_item;
   dvrt_pkg::rsp_type  rsp;

   // register port never stalls
   assign csr_ready = 1'b1;

   always_comb begin
      own_address_in = own_address_ff;
      hop_limit_in   = hop_limit_ff;
      if (csr_valid) begin
         case (csr_index)
            dvrt_pkg::CSR_OWN_ADDRESS: own_address_in = csr_data;
            dvrt_pkg::CSR_HOP_LIMIT:   hop_limit_in   = csr_data[3:0];
            default: begin
               // unknown index, write dropped
               own_address_in = own_address_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= '0;
         hop_limit_ff   <= dvrt_pkg::HOP_LIMIT_RESET;
      end else begin
         own_address_ff <= own_address_in;
         hop_limit_ff   <= hop_limit_in;
      end
   end

   // front: takes words and works out network, gateway and new hop count
   dvrt_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .hop_limit  (hop_limit_ff),
      .q_full     (q_full),
      .push       (push),
      .push_item  (push_item)
   );

   // short queue so the front keeps taking words while the engine works
   dvrt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (q_empty)
   );

   // table engine with its own result register
   dvrt_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .own_address (own_address_ff),
      .q_empty     (q_empty),
      .pop_item    (pop_item),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp)
   );

   // result word packing
   assign rsp_tdata = {4'd0, rsp.metric, rsp.gateway, rsp.network};
   assign rsp_tuser = {rsp.entry_valid, rsp.status};
   assign rsp_tlast = rsp.last;

endmodule

`default_nettype wire

>>> tb/tb_distance_vector_route_table_unit.sv
// tb_distance_vector_route_table_unit: self-checking bench for the distance-vector route table
// drives request and register words and checks every result word against a behavioural table
// depends on dvrt_pkg and distance_vector_route_table_unit
`timescale 1ns / 1ps

module tb_distance_vector_route_table_unit;

   localparam int TABLE_ENTRIES    = 16;
   localparam int POOL_SIZE        = 10;      // networks used while the table still has room
   localparam int SETTLE_CYCLES    = 12;      // settle time after the owed words, before register writes
   localparam int LONG_HOLD_CYCLES = 200;     // result side back-pressure, long enough to fill
   localparam int TIMEOUT_NS       = 2_000_000;
   localparam int DIRECTED_ROWS    = 17;

   // no register sits behind this index, so a write to it must change nothing
   localparam logic [7:0] CSR_SPARE_INDEX = 8'hFE;

   localparam logic CHECK_LISTED    = 1'b1;   // expected word written in the row
   localparam logic CHECK_PREDICTED = 1'b0;   // expected words come from the behavioural table

   typedef struct packed {
      logic [1:0]        kind;
      logic [31:0]       address;
      logic [31:0]       via_address;
      logic [3:0]        hops;
      logic              listed;
      dvrt_pkg::rsp_type want;
   } stim_row_type;

   // directed rows, all run with the reset register values (own address 0, hop limit 15)
   localparam stim_row_type DIRECTED [0:DIRECTED_ROWS-1] = '{
      // dump of an empty table
      '{dvrt_pkg::KIND_DUMP,    32'h0000_0000, 32'h0000_0000, 4'd0,  CHECK_LISTED,
        '{dvrt_pkg::STATUS_DUMP,      24'h000000, 32'h0000_0000, 4'd0, 1'b0, 1'b1}},
      // lookup with nothing stored
      '{dvrt_pkg::KIND_LOOKUP,  32'h0A00_0005, 32'h0000_0000, 4'd0,  CHECK_LISTED,
        '{dvrt_pkg::STATUS_UNREACH,   24'h0A0000, 32'h0000_0000, 4'd0, 1'b0, 1'b1}},
      '{dvrt_pkg::KIND_CONNECT, 32'h0A00_0105, 32'hFFFF_FFFF, 4'd15, CHECK_LISTED,
        '{dvrt_pkg::STATUS_INSTALLED, 24'h0A0001, 32'h0A00_0105,
          dvrt_pkg::HOP_LOCAL, 1'b1, 1'b1}},
      '{dvrt_pkg::KIND_CONNECT, 32'hFFFF_FFFF, 32'h0000_0000, 4'd0,  CHECK_LISTED,
        '{dvrt_pkg::STATUS_INSTALLED, 24'hFFFFFF, 32'hFFFF_FFFF,
          dvrt_pkg::HOP_LOCAL, 1'b1, 1'b1}},
      '{dvrt_pkg::KIND_CONNECT, 32'h0000_0000, 32'hFFFF_FFFF, 4'd15, CHECK_LISTED,
        '{dvrt_pkg::STATUS_INSTALLED, 24'h000000, 32'h0000_0000,
          dvrt_pkg::HOP_LOCAL, 1'b1, 1'b1}},
      // advert no better than the local route
      '{dvrt_pkg::KIND_ADVERT,  32'h0A00_0100, 32'hC0A8_0002, 4'd0,  CHECK_LISTED,
        '{dvrt_pkg::STATUS_IGNORED,   24'h0A0001, 32'h0000_0000, 4'd0, 1'b0, 1'b1}},
      // new network landing exactly on the hop limit
      '{dvrt_pkg::KIND_ADVERT,  32'h1400_0000, 32'hAC10_0001, 4'd14, CHECK_LISTED,
        '{dvrt_pkg::STATUS_INSTALLED, 24'h140000, 32'hAC10_0001, 4'd15, 1'b1, 1'b1}},
      // one past the hop limit
      '{dvrt_pkg::KIND_ADVERT,  32'h1400_007F, 32'h0102_0304, 4'd15, CHECK_LISTED,
        '{dvrt_pkg::STATUS_IGNORED,   24'h140000, 32'h0000_0000, 4'd0, 1'b0, 1'b1}},
      // better route replaces the stored one
      '{dvrt_pkg::KIND_ADVERT,  32'h1400_00AA, 32'h0506_0708, 4'd3,  CHECK_LISTED,
        '{dvrt_pkg::STATUS_INSTALLED, 24'h140000, 32'h0506_0708, 4'd4, 1'b1, 1'b1}},
      // equal count is not better
      '{dvrt_pkg::KIND_ADVERT,  32'h1400_0055, 32'h0A0B_0C0D, 4'd3,  CHECK_LISTED,
        '{dvrt_pkg::STATUS_IGNORED,   24'h140000, 32'h0000_0000, 4'd0, 1'b0, 1'b1}},
      '{dvrt_pkg::KIND_ADVERT,  32'h1E00_00FF, 32'hFFFF_FFFF, 4'd0,  CHECK_LISTED,
        '{dvrt_pkg::STATUS_INSTALLED, 24'h1E0000, 32'hFFFF_FFFF,
          dvrt_pkg::HOP_LOCAL, 1'b1, 1'b1}},
      '{dvrt_pkg::KIND_LOOKUP,  32'h1400_00FF, 32'h0000_0000, 4'd0,  CHECK_LISTED,
        '{dvrt_pkg::STATUS_FOUND,     24'h140000, 32'h0506_0708, 4'd4, 1'b1, 1'b1}},
      // connect overwrites a learnt route
      '{dvrt_pkg::KIND_CONNECT, 32'h1400_0001, 32'h0000_0000, 4'd0,  CHECK_LISTED,
        '{dvrt_pkg::STATUS_INSTALLED, 24'h140000, 32'h1400_0001,
          dvrt_pkg::HOP_LOCAL, 1'b1, 1'b1}},
      '{dvrt_pkg::KIND_LOOKUP,  32'hFFFF_FF00, 32'hFFFF_FFFF, 4'd15, CHECK_LISTED,
        '{dvrt_pkg::STATUS_FOUND,     24'hFFFFFF, 32'hFFFF_FFFF,
          dvrt_pkg::HOP_LOCAL, 1'b1, 1'b1}},
      '{dvrt_pkg::KIND_LOOKUP,  32'h0000_0099, 32'h0000_0000, 4'd0,  CHECK_LISTED,
        '{dvrt_pkg::STATUS_FOUND,     24'h000000, 32'h0000_0000,
          dvrt_pkg::HOP_LOCAL, 1'b1, 1'b1}},
      '{dvrt_pkg::KIND_ADVERT,  32'hFFFF_FF01, 32'h0000_0000, 4'd15, CHECK_LISTED,
        '{dvrt_pkg::STATUS_IGNORED,   24'hFFFFFF, 32'h0000_0000, 4'd0, 1'b0, 1'b1}},
      // dump of a partly filled table
      '{dvrt_pkg::KIND_DUMP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, CHECK_PREDICTED, '0}
   };

   // dut ports; the ones the bench drives are known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;     // address [31:0], via_address [63:32], hops [67:64]
   logic [1:0]  req_tuser = '0;     // kind [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;          // network [23:0], gateway [55:24], metric [59:56]
   logic [3:0]  rsp_tuser;          // status [2:0], entry_valid [3]
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // behavioural copy of the route table and its registers
   logic        route_valid    [TABLE_ENTRIES] = '{default: 1'b0};
   logic [23:0] route_network  [TABLE_ENTRIES];
   logic [31:0] route_gateway  [TABLE_ENTRIES];
   logic [3:0]  route_hops     [TABLE_ENTRIES];
   logic [31:0] own_address_reg = '0;
   logic [3:0]  hop_limit_reg   = dvrt_pkg::HOP_LIMIT_RESET;

   dvrt_pkg::rsp_type results_due [$];    // result words owed by the block, oldest first
   logic [23:0] net_pool [POOL_SIZE];
   int          mismatches = 0;

   // knobs shared between the stimulus thread and the result side
   bit          no_idle = 1'b0;     // both sides run flat out while set
   int          hold_request = 0;   // one-off result side stall, in cycles

   distance_vector_route_table_unit #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // hard stop in case a handshake never completes
   initial begin
      #TIMEOUT_NS;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic void queue_result(input logic [2:0] status, input logic [23:0] network,
                                        input logic [31:0] gateway, input logic [3:0] metric,
                                        input logic entry_valid, input logic last);
      dvrt_pkg::rsp_type word;
      word.status      = status;
      word.network     = network;
      word.gateway     = gateway;
      word.metric      = metric;
      word.entry_valid = entry_valid;
      word.last        = last;
      results_due = {results_due, word};
   endfunction

   // applies one accepted request word to the behavioural table and queues its results
   function automatic void apply_route_item(input logic [1:0] kind, input logic [31:0] address,
                                            input logic [31:0] via, input logic [3:0] hops);
      logic [23:0] network;
      logic [4:0]  offered;
      int          slot, free_slot, final_slot, i;
      network    = address[31:8];
      offered    = {1'b0, hops} + 5'd1;   // one wider, so 15 + 1 does not wrap
      slot       = -1;
      free_slot  = -1;
      final_slot = -1;
      for (i = 0; i < TABLE_ENTRIES; i++) begin
         if (route_valid[i] && route_network[i] == network && slot < 0) slot = i;
         if (!route_valid[i] && free_slot < 0) free_slot = i;
         if (route_valid[i]) final_slot = i;
      end
      case (kind)
         dvrt_pkg::KIND_LOOKUP: begin
            if (slot >= 0)
               queue_result(dvrt_pkg::STATUS_FOUND, network, route_gateway[slot],
                            route_hops[slot], 1'b1, 1'b1);
            else
               queue_result(dvrt_pkg::STATUS_UNREACH, network, '0, '0, 1'b0, 1'b1);
         end
         dvrt_pkg::KIND_DUMP: begin
            // slot order, last flag on the highest valid slot, one blank word if empty
            if (final_slot < 0) queue_result(dvrt_pkg::STATUS_DUMP, '0, '0, '0, 1'b0, 1'b1);
            for (i = 0; i < TABLE_ENTRIES; i++) begin
               if (route_valid[i])
                  queue_result(dvrt_pkg::STATUS_DUMP, route_network[i], own_address_reg,
                               route_hops[i], 1'b1, i == final_slot);
            end
         end
         default: begin
            // connect installs if room; an advert must fit the limit and beat what is stored
            if (kind == dvrt_pkg::KIND_ADVERT && (offered > {1'b0, hop_limit_reg} ||
                (slot >= 0 && offered >= {1'b0, route_hops[slot]}))) begin
               queue_result(dvrt_pkg::STATUS_IGNORED, network, '0, '0, 1'b0, 1'b1);
            end else begin
               if (slot < 0) slot = free_slot;
               if (slot < 0) begin
                  queue_result(dvrt_pkg::STATUS_FULL, network, '0, '0, 1'b0, 1'b1);
               end else begin
                  route_valid[slot]   = 1'b1;
                  route_network[slot] = network;
                  route_gateway[slot] = (kind == dvrt_pkg::KIND_CONNECT) ? address : via;
                  route_hops[slot]    = (kind == dvrt_pkg::KIND_CONNECT) ?
                                        dvrt_pkg::HOP_LOCAL : offered[3:0];
                  queue_result(dvrt_pkg::STATUS_INSTALLED, network, route_gateway[slot],
                               route_hops[slot], 1'b1, 1'b1);
               end
            end
         end
      endcase
   endfunction

   // offers one request word after a random gap, predicts once it is taken
   task automatic send_item(input logic [1:0] kind, input logic [31:0] address,
                            input logic [31:0] via, input logic [3:0] hops);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, hops, via, address};
      do @(posedge clock); while (!req_tready);
      apply_route_item(kind, address, via, hops);
   endtask

   // valid is left high so back-to-back writes never drop it; the caller lowers it
   task automatic write_reg(input logic [7:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         dvrt_pkg::CSR_OWN_ADDRESS: own_address_reg = value;
         dvrt_pkg::CSR_HOP_LIMIT:   hop_limit_reg   = value[3:0];
         default:                   ;
      endcase
   endtask

   // stop offering and wait for every owed word, then let the pipe settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [31:0] own_address, input logic [31:0] limit_word,
                             input bit with_spare);
      drain();
      if (with_spare) write_reg(CSR_SPARE_INDEX, $urandom);
      write_reg(dvrt_pkg::CSR_OWN_ADDRESS, own_address);
      write_reg(dvrt_pkg::CSR_HOP_LIMIT, limit_word);
      csr_valid <= 1'b0;
   endtask

   // random request words; networks are drawn so that most of them hit the table
   task automatic run_random(input int count, input bit table_full, input bit with_hold);
      logic [1:0]  kind;
      logic [23:0] network;
      int          pick, i;
      for (i = 0; i < count; i++) begin
         no_idle = (i >= 30 && i < 55);
         if (with_hold && i == 10) hold_request = LONG_HOLD_CYCLES;
         pick = $urandom_range(0, 99);
         if (pick < 20)      kind = dvrt_pkg::KIND_CONNECT;
         else if (pick < 62) kind = dvrt_pkg::KIND_ADVERT;
         else if (pick < 90) kind = dvrt_pkg::KIND_LOOKUP;
         else                kind = dvrt_pkg::KIND_DUMP;
         // once full every slot is valid, so reading a stored network is safe
         if (table_full && $urandom_range(0, 3) != 0)
            network = route_network[$urandom_range(0, TABLE_ENTRIES - 1)];
         else if (!table_full && (kind != dvrt_pkg::KIND_LOOKUP || $urandom_range(0, 3) != 0))
            network = net_pool[$urandom_range(0, POOL_SIZE - 1)];
         else
            network = 24'($urandom);
         send_item(kind, {network, 8'($urandom)}, $urandom, 4'($urandom));
      end
      no_idle = 1'b0;
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("t=%0t %s mismatch: expected 'h%0h, actual 'h%0h", $time, field, want, got);
         mismatches++;
      end
   endtask

   // result side: random stalls, one long hold on request, checks each word taken
   initial begin
      dvrt_pkg::rsp_type got, want;
      int                stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request != 0) begin
            stall = hold_request;
            hold_request = 0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.status      = rsp_tuser[2:0];
         got.network     = rsp_tdata[23:0];
         got.gateway     = rsp_tdata[55:24];
         got.metric      = rsp_tdata[59:56];
         got.entry_valid = rsp_tuser[3];
         got.last        = rsp_tlast;
         if (results_due.size() == 0) begin
            $display("t=%0t result word with nothing owed: expected none, actual 'h%0h",
                     $time, got);
            mismatches++;
         end else begin
            want = results_due.pop_front();
            compare_field("status",      32'(want.status),      32'(got.status));
            compare_field("network",     32'(want.network),     32'(got.network));
            compare_field("gateway",     want.gateway,          got.gateway);
            compare_field("metric",      32'(want.metric),      32'(got.metric));
            compare_field("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
            compare_field("last",        32'(want.last),        32'(got.last));
         end
      end
   end

   // stimulus: directed rows, then random phases under several register settings
   initial begin
      int i;
      for (i = 0; i < POOL_SIZE; i++) net_pool[i] = 24'($urandom);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++) begin
         send_item(DIRECTED[i].kind, DIRECTED[i].address, DIRECTED[i].via_address,
                   DIRECTED[i].hops);
         // swap the predicted word for the one written in the row
         if (DIRECTED[i].listed) begin
            results_due[results_due.size() - 1] = DIRECTED[i].want;
         end
      end

      // table still has room; the first phase also backs up the result side
      set_config(32'hFFFF_FFFF, 32'd15, 1'b0);
      run_random(80, 1'b0, 1'b1);
      set_config($urandom, 32'd1, 1'b0);
      run_random(80, 1'b0, 1'b0);

      // fill the table with fresh networks until connects and adverts report full
      set_config(32'h0000_0000, 32'd15, 1'b0);
      for (i = 0; i < TABLE_ENTRIES + 5; i++) begin
         send_item((i >= TABLE_ENTRIES + 3) ? dvrt_pkg::KIND_ADVERT : dvrt_pkg::KIND_CONNECT,
                   $urandom, $urandom, 4'($urandom_range(0, 13)));
      end
      send_item(dvrt_pkg::KIND_DUMP, $urandom, $urandom, 4'($urandom));

      // hop limit zero ignores every advert; the spare index must leave both registers alone
      set_config($urandom, 32'hFFFF_FFF0, 1'b1);
      run_random(60, 1'b1, 1'b0);
      set_config($urandom, ($urandom & 32'hFFFF_FFF0) | 32'($urandom_range(2, 14)), 1'b0);
      run_random(90, 1'b1, 1'b0);
      set_config($urandom, 32'd15, 1'b0);
      run_random(90, 1'b1, 1'b0);

      drain();
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
